FILE: design/lpft_pkg.sv
// lpft_pkg: widths, register indexes and reset values for the lidar point
// filter and transform block
// no dependencies
package lpft_pkg;

    localparam int TIME_W      = 62;
    localparam int INTERVAL_W  = 20;
    localparam int INTEN_W     = 8;
    localparam int RANGE_W     = 40;
    localparam int ROW_W       = 48;
    localparam int COEF_W      = 16;
    localparam int PT_W        = 20;
    localparam int OUT_W       = 21;
    localparam int PROD_W      = COEF_W + PT_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int FRAC_W      = 14;
    localparam int SUM_W       = ACC_W + 1;
    localparam int RND_W       = SUM_W - FRAC_W;
    localparam int WIDE_W      = RND_W + 1;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 48;

    localparam logic [CFG_INDEX_W-1:0] REG_POINT_INTERVAL = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_INTENSITY  = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_RANGE_SQ   = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_RANGE_SQ   = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ROT_ROW0       = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ROT_ROW1       = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_ROT_ROW2       = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_TRANSLATION    = 4'd7;

    localparam logic [INTERVAL_W-1:0] RST_POINT_INTERVAL = 20'd1000;
    localparam logic [INTEN_W-1:0]    RST_MIN_INTENSITY  = 8'd0;
    localparam logic [RANGE_W-1:0]    RST_MIN_RANGE_SQ   = 40'd0;
    localparam logic [RANGE_W-1:0]    RST_MAX_RANGE_SQ   = 40'hFF_FFFF_FFFF;
    localparam logic [ROW_W-1:0]      RST_ROT_ROW0       = 48'h0000_0000_4000;
    localparam logic [ROW_W-1:0]      RST_ROT_ROW1       = 48'h0000_4000_0000;
    localparam logic [ROW_W-1:0]      RST_ROT_ROW2       = 48'h4000_0000_0000;
    localparam logic [ROW_W-1:0]      RST_TRANSLATION    = 48'd0;

    localparam logic signed [SUM_W-1:0]  ROUND_HALF = SUM_W'(8192);
    localparam logic signed [WIDE_W-1:0] OUT_MAX    = WIDE_W'(1048575);
    localparam logic signed [WIDE_W-1:0] OUT_MIN    = -WIDE_W'(1048576);

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [PROD_W-1:0] prod_t;

endpackage

FILE: design/lidar_point_filter_transform.sv
// lidar_point_filter_transform: point timestamping, range/intensity filter
// and fixed-point rigid transform into the body frame
// depends on lpft_pkg
//
// channel   handshake             payload
// input     in_valid / in_ready   scan_start scan_time scan_end point_x/y/z point_intensity
// output    out_valid / out_ready out_time out_x out_y out_z out_intensity
// config    cfg_we                cfg_index cfg_data
//
// one item per cycle while the output is not stalled; a kept item passes the input, product and result registers
// stages: input register, product register (nine Q1.14 multiplies, three squares),
// result register (sums, rounding, translation, saturation, range compare)
// time state is updated at acceptance, so back-to-back items see the right time
// each stage holds only while the one after it is full and stalled
// reset loads the register defaults and clears the time state and all valids
module lidar_point_filter_transform
    import lpft_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_we,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          scan_start,
    input  logic [TIME_W-1:0]             scan_time,
    input  logic                          scan_end,
    input  logic signed [PT_W-1:0]        point_x,
    input  logic signed [PT_W-1:0]        point_y,
    input  logic signed [PT_W-1:0]        point_z,
    input  logic [INTEN_W-1:0]            point_intensity,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [TIME_W-1:0]             out_time,
    output logic signed [OUT_W-1:0]       out_x,
    output logic signed [OUT_W-1:0]       out_y,
    output logic signed [OUT_W-1:0]       out_z,
    output logic [INTEN_W-1:0]            out_intensity
);

    // configuration
    logic [INTERVAL_W-1:0] point_interval_reg;
    logic [INTEN_W-1:0]    min_intensity_reg;
    logic [RANGE_W-1:0]    min_range_sq_reg;
    logic [RANGE_W-1:0]    max_range_sq_reg;
    logic [ROW_W-1:0]      rot_row_reg [3];
    logic [ROW_W-1:0]      translation_reg;

    // time state
    logic [TIME_W-1:0] next_point_time_reg, next_point_time_next;
    logic [TIME_W-1:0] head_time_reg, head_time_next;
    logic [TIME_W-1:0] point_time;
    logic [TIME_W-1:0] time_plus;
    logic              in_fire;

    // stage 1
    logic                   s1_valid_reg;
    logic [TIME_W-1:0]      s1_time_reg;
    logic                   s1_time_ok_reg;
    logic signed [PT_W-1:0] s1_pt_reg [3];
    logic [INTEN_W-1:0]     s1_inten_reg;

    // stage 2
    logic                   s2_valid_reg;
    logic [TIME_W-1:0]      s2_time_reg;
    logic                   s2_pass_reg;
    logic [INTEN_W-1:0]     s2_inten_reg;
    prod_t                  s2_prod_reg [3][3];
    logic [RANGE_W-1:0]     s2_sq_reg [3];

    // output stage
    logic                    out_valid_reg, out_valid_next;
    logic [TIME_W-1:0]       out_time_reg;
    logic signed [OUT_W-1:0] out_pt_reg [3];
    logic signed [OUT_W-1:0] out_pt_next [3];
    logic [INTEN_W-1:0]      out_inten_reg;

    logic en1, en2, en3;
    logic [RANGE_W-1:0] range_sq;
    logic               keep;

    assign en3      = !out_valid_reg || out_ready;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;
    assign in_fire  = in_valid && in_ready;

    // configuration writes, out-of-range indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_interval_reg <= RST_POINT_INTERVAL;
            min_intensity_reg  <= RST_MIN_INTENSITY;
            min_range_sq_reg   <= RST_MIN_RANGE_SQ;
            max_range_sq_reg   <= RST_MAX_RANGE_SQ;
            rot_row_reg[0]     <= RST_ROT_ROW0;
            rot_row_reg[1]     <= RST_ROT_ROW1;
            rot_row_reg[2]     <= RST_ROT_ROW2;
            translation_reg    <= RST_TRANSLATION;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POINT_INTERVAL: point_interval_reg <= cfg_data[INTERVAL_W-1:0];
                REG_MIN_INTENSITY:  min_intensity_reg  <= cfg_data[INTEN_W-1:0];
                REG_MIN_RANGE_SQ:   min_range_sq_reg   <= cfg_data[RANGE_W-1:0];
                REG_MAX_RANGE_SQ:   max_range_sq_reg   <= cfg_data[RANGE_W-1:0];
                REG_ROT_ROW0:       rot_row_reg[0]     <= cfg_data[ROW_W-1:0];
                REG_ROT_ROW1:       rot_row_reg[1]     <= cfg_data[ROW_W-1:0];
                REG_ROT_ROW2:       rot_row_reg[2]     <= cfg_data[ROW_W-1:0];
                REG_TRANSLATION:    translation_reg    <= cfg_data[ROW_W-1:0];
                default:            ;
            endcase
        end
    end

    // point time and head update happen as the item is taken
    always_comb
    begin
        point_time           = scan_start ? scan_time : next_point_time_reg;
        time_plus            = point_time + TIME_W'(point_interval_reg);
        next_point_time_next = next_point_time_reg;
        head_time_next       = head_time_reg;
        if (in_fire)
        begin
            next_point_time_next = time_plus;
            if (scan_end && (time_plus > head_time_reg))
                head_time_next = time_plus;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_point_time_reg <= '0;
            head_time_reg       <= '0;
        end
        else
        begin
            next_point_time_reg <= next_point_time_next;
            head_time_reg       <= head_time_next;
        end
    end

    // valid bits of the three stages
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (en3)
            out_valid_next = s2_valid_reg && keep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_valid_reg <= in_valid;
            if (en2)
                s2_valid_reg <= s1_valid_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    // stage 1: capture the point
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_time_reg    <= point_time;
            s1_time_ok_reg <= (point_time >= head_time_reg);
            s1_pt_reg[0]   <= point_x;
            s1_pt_reg[1]   <= point_y;
            s1_pt_reg[2]   <= point_z;
            s1_inten_reg   <= point_intensity;
        end
    end

    // stage 2: rotation products, squares and the time/x/intensity pass flag
    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_time_reg  <= s1_time_reg;
            s2_inten_reg <= s1_inten_reg;
            s2_pass_reg  <= s1_time_ok_reg && (s1_pt_reg[0] != '0)
                            && (s1_inten_reg >= min_intensity_reg);
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    s2_prod_reg[r][c] <= coef_t'(rot_row_reg[r][COEF_W*c +: COEF_W])
                                         * s1_pt_reg[c];
                end
            end
            for (int c = 0; c < 3; c++)
            begin
                s2_sq_reg[c] <= RANGE_W'(s1_pt_reg[c] * s1_pt_reg[c]);
            end
        end
    end

    // stage 3: sum, round half up, translate, saturate, range window
    always_comb
    begin
        logic signed [ACC_W-1:0]  acc;
        logic signed [SUM_W-1:0]  rnd;
        logic signed [WIDE_W-1:0] wide;
        range_sq = s2_sq_reg[0] + s2_sq_reg[1] + s2_sq_reg[2];
        keep     = s2_pass_reg && (range_sq >= min_range_sq_reg)
                   && (range_sq <= max_range_sq_reg);
        for (int r = 0; r < 3; r++)
        begin
            acc  = ACC_W'(s2_prod_reg[r][0]) + ACC_W'(s2_prod_reg[r][1])
                   + ACC_W'(s2_prod_reg[r][2]);
            rnd  = SUM_W'(acc) + ROUND_HALF;
            wide = WIDE_W'($signed(rnd[SUM_W-1:FRAC_W]))
                   + WIDE_W'(coef_t'(translation_reg[COEF_W*r +: COEF_W]));
            if (wide > OUT_MAX)
                out_pt_next[r] = OUT_MAX[OUT_W-1:0];
            else if (wide < OUT_MIN)
                out_pt_next[r] = OUT_MIN[OUT_W-1:0];
            else
                out_pt_next[r] = wide[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            out_time_reg  <= s2_time_reg;
            out_inten_reg <= s2_inten_reg;
            for (int r = 0; r < 3; r++)
            begin
                out_pt_reg[r] <= out_pt_next[r];
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_time      = out_time_reg;
    assign out_x         = out_pt_reg[0];
    assign out_y         = out_pt_reg[1];
    assign out_z         = out_pt_reg[2];
    assign out_intensity = out_inten_reg;

    // head time only moves forward
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |-> head_time_reg >= $past(head_time_reg))
        else $error("head time decreased");

    // a new result comes only from a full stage 2
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s2_valid_reg))
        else $error("result without a stage 2 item");

    // a continuing item with a nonzero interval moves the point time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !scan_start && (point_interval_reg != '0)
        |=> next_point_time_reg != $past(next_point_time_reg))
        else $error("point time did not advance");

endmodule
